// ===== rtl/rntd_pkg.sv =====
// ----------------------------------------------------------------------------
// rntd_pkg: shared types and constants for the radix digit converter
// Queue word layout, back-end state codes and the digit-to-ASCII mapping.
// ----------------------------------------------------------------------------
package rntd_pkg;

    localparam int WHOLE_W      = 31;
    localparam int FRAC_W       = 32;
    localparam int BASE_W       = 5;
    localparam int DIGIT_W      = 4;
    localparam int CHAR_W       = 7;
    localparam int WHOLE_DIGITS = 31;
    localparam int DIGIT_IDX_W  = 5;
    localparam int QUEUE_DEPTH  = 2;

    localparam logic [BASE_W-1:0] BASE_RESET = 5'd10;
    localparam logic [BASE_W-1:0] BASE_MIN   = 5'd2;
    localparam logic [BASE_W-1:0] BASE_MAX   = 5'd16;

    localparam logic [CHAR_W-1:0] CH_ZERO = 7'h30;
    localparam logic [CHAR_W-1:0] CH_A    = 7'h41;
    localparam logic [CHAR_W-1:0] CH_DOT  = 7'h2E;
    localparam logic [DIGIT_W-1:0] DIGIT_TEN = 4'd10;

    // one classified number waiting for the back end
    typedef struct packed {
        logic [WHOLE_W-1:0] whole;
        logic [FRAC_W-1:0]  frac;
        logic [BASE_W-1:0]  base;
        logic               whole_zero;
    } rntd_word_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_DIV,
        B_WHOLE,
        B_DOT,
        B_FRAC
    } back_state_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < DIGIT_TEN)
            c = CH_ZERO + {3'b000, d};
        else
            c = CH_A + {3'b000, d - DIGIT_TEN};
        return c;
    endfunction

endpackage

// ===== rtl/rntd_front.sv =====
// ----------------------------------------------------------------------------
// rntd_front: input side of the radix digit converter
// Holds the base register, clamps it into range and tags each number.
// ----------------------------------------------------------------------------
module rntd_front
    import rntd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [BASE_W-1:0]   radix_base,
    input  logic                item_valid,
    output logic                item_stall,
    input  logic [WHOLE_W-1:0]  whole_part,
    input  logic [FRAC_W-1:0]   fraction_part,
    input  logic                q_full,
    output logic                q_push,
    output rntd_word_t          q_word
);

    logic [BASE_W-1:0] base_reg;
    logic [BASE_W-1:0] base_next;
    logic [BASE_W-1:0] base_eff;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        base_next = base_reg;
        if (cfg_valid)
            base_next = radix_base;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            base_reg <= BASE_RESET;
        else
            base_reg <= base_next;
    end

    // treat codes below two as binary and above sixteen as hex
    always_comb
    begin
        if (base_reg < BASE_MIN)
            base_eff = BASE_MIN;
        else if (base_reg > BASE_MAX)
            base_eff = BASE_MAX;
        else
            base_eff = base_reg;
    end

    assign item_stall        = q_full;
    assign q_push            = item_valid && !q_full;
    assign q_word.whole      = whole_part;
    assign q_word.frac       = fraction_part;
    assign q_word.base       = base_eff;
    assign q_word.whole_zero = (whole_part == '0);

endmodule

// ===== rtl/rntd_fifo.sv =====
// ----------------------------------------------------------------------------
// rntd_fifo: short queue between front and back ends
// Two-entry register queue of classified numbers.
// ----------------------------------------------------------------------------
module rntd_fifo
    import rntd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  rntd_word_t push_word,
    output logic       full,
    input  logic       pop,
    output logic       empty,
    output rntd_word_t pop_word
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_P  = PTR_W'(QUEUE_DEPTH - 1);

    rntd_word_t       mem_reg [0:QUEUE_DEPTH-1];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == DEPTH_C);
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_word = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST_P) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST_P) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_word;
    end

endmodule

// ===== rtl/rntd_back.sv =====
// ----------------------------------------------------------------------------
// rntd_back: digit engine of the radix digit converter
// Serial divider for whole digits, digit stack, fraction multiplier, output.
// ----------------------------------------------------------------------------
module rntd_back
    import rntd_pkg::*;
#(
    parameter int FRACTION_DIGITS = 4
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    input  rntd_word_t         q_word,
    output logic               q_pop,
    output logic               char_valid,
    input  logic               char_stall,
    output logic [CHAR_W-1:0]  ascii_char,
    output logic               last_char
);

    localparam int FC_W = (FRACTION_DIGITS > 1) ? $clog2(FRACTION_DIGITS) : 1;
    localparam logic [FC_W-1:0] FC_LAST = FC_W'(FRACTION_DIGITS - 1);
    localparam logic [DIGIT_IDX_W-1:0] BIT_LAST = DIGIT_IDX_W'(WHOLE_W - 1);
    localparam int PROD_W = FRAC_W + BASE_W;

    back_state_t              state_reg, state_next;
    logic [WHOLE_W-1:0]       quot_reg, quot_next;
    logic [DIGIT_W-1:0]       rem_reg, rem_next;
    logic [FRAC_W-1:0]        frac_reg, frac_next;
    logic [BASE_W-1:0]        base_reg, base_next;
    logic [DIGIT_IDX_W-1:0]   bcnt_reg, bcnt_next;
    logic [DIGIT_IDX_W-1:0]   nd_reg, nd_next;
    logic [DIGIT_IDX_W-1:0]   ecnt_reg, ecnt_next;
    logic [FC_W-1:0]          fcnt_reg, fcnt_next;
    logic [DIGIT_W-1:0]       digit_reg [0:WHOLE_DIGITS-1];
    logic                     push_digit;

    logic                     out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]        char_reg, char_next;
    logic                     last_reg, last_next;
    logic                     can_load, load;

    logic [BASE_W-1:0]        trial;
    logic                     ge;
    logic [DIGIT_W-1:0]       rem_step;
    logic [PROD_W-1:0]        prod;

    assign can_load = !out_valid_reg || !char_stall;

    // one restoring division step: remainder stays below the base
    assign trial    = {rem_reg, quot_reg[WHOLE_W-1]};
    assign ge       = (trial >= base_reg);
    assign rem_step = ge ? DIGIT_W'(trial - base_reg) : trial[DIGIT_W-1:0];
    assign prod     = PROD_W'(frac_reg) * PROD_W'(base_reg);

    always_comb
    begin
        state_next  = state_reg;
        quot_next   = quot_reg;
        rem_next    = rem_reg;
        frac_next   = frac_reg;
        base_next   = base_reg;
        bcnt_next   = bcnt_reg;
        nd_next     = nd_reg;
        ecnt_next   = ecnt_reg;
        fcnt_next   = fcnt_reg;
        push_digit  = 1'b0;
        q_pop       = 1'b0;
        load        = 1'b0;
        char_next   = char_reg;
        last_next   = last_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop     = 1'b1;
                    quot_next = q_word.whole;
                    frac_next = q_word.frac;
                    base_next = q_word.base;
                    rem_next  = '0;
                    bcnt_next = '0;
                    nd_next   = '0;
                    state_next = q_word.whole_zero ? B_DOT : B_DIV;
                end
            end
            B_DIV:
            begin
                rem_next  = rem_step;
                quot_next = {quot_reg[WHOLE_W-2:0], ge};
                bcnt_next = bcnt_reg + 1'b1;
                if (bcnt_reg == BIT_LAST)
                begin
                    push_digit = 1'b1;
                    nd_next    = nd_reg + 1'b1;
                    bcnt_next  = '0;
                    rem_next   = '0;
                    if (quot_next == '0)
                    begin
                        ecnt_next  = nd_reg;
                        state_next = B_WHOLE;
                    end
                end
            end
            B_WHOLE:
            begin
                if (can_load)
                begin
                    load      = 1'b1;
                    char_next = digit_char(digit_reg[ecnt_reg]);
                    last_next = 1'b0;
                    ecnt_next = ecnt_reg - 1'b1;
                    if (ecnt_reg == '0)
                        state_next = B_DOT;
                end
            end
            B_DOT:
            begin
                if (can_load)
                begin
                    load       = 1'b1;
                    char_next  = CH_DOT;
                    last_next  = 1'b0;
                    fcnt_next  = '0;
                    state_next = B_FRAC;
                end
            end
            B_FRAC:
            begin
                if (can_load)
                begin
                    load      = 1'b1;
                    char_next = digit_char(prod[FRAC_W+DIGIT_W-1:FRAC_W]);
                    last_next = (fcnt_reg == FC_LAST);
                    frac_next = prod[FRAC_W-1:0];
                    fcnt_next = fcnt_reg + 1'b1;
                    if (fcnt_reg == FC_LAST)
                        state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
            out_valid_next = 1'b1;
        else if (!char_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
            bcnt_reg      <= '0;
            nd_reg        <= '0;
            ecnt_reg      <= '0;
            fcnt_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            bcnt_reg      <= bcnt_next;
            nd_reg        <= nd_next;
            ecnt_reg      <= ecnt_next;
            fcnt_reg      <= fcnt_next;
        end
    end

    // remainder of the final step goes onto the digit stack
    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        frac_reg <= frac_next;
        base_reg <= base_next;
        char_reg <= char_next;
        last_reg <= last_next;
        if (push_digit)
            digit_reg[nd_reg] <= rem_step;
    end

    assign char_valid = out_valid_reg;
    assign ascii_char = char_reg;
    assign last_char  = last_reg;

endmodule

// ===== rtl/radix_number_to_digits_unit.sv =====
// ----------------------------------------------------------------------------
// radix_number_to_digits_unit: fixed-point number to ASCII digit string
// Whole digits in base 2..16, then '.', then FRACTION_DIGITS fraction digits.
// ----------------------------------------------------------------------------
// Per number: the back end dequeues it, the serial divider produces each whole
// digit, then one character per cycle while char_stall is low.
// A two-word queue takes new numbers while the divider works.
// Reset clears the queue, sequencer and output valid; the base resets to 10.
module radix_number_to_digits_unit
    import rntd_pkg::*;
#(
    parameter int FRACTION_DIGITS = 4
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [BASE_W-1:0]  radix_base,
    input  logic               item_valid,
    output logic               item_stall,
    input  logic [WHOLE_W-1:0] whole_part,
    input  logic [FRAC_W-1:0]  fraction_part,
    output logic               char_valid,
    input  logic               char_stall,
    output logic [CHAR_W-1:0]  ascii_char,
    output logic               last_char
);

    rntd_word_t push_word;
    rntd_word_t pop_word;
    logic       q_push, q_full, q_pop, q_empty;

    rntd_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .radix_base    (radix_base),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .whole_part    (whole_part),
        .fraction_part (fraction_part),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_word        (push_word)
    );

    rntd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_word (push_word),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .pop_word  (pop_word)
    );

    rntd_back #(
        .FRACTION_DIGITS (FRACTION_DIGITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_word     (pop_word),
        .q_pop      (q_pop),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .ascii_char (ascii_char),
        .last_char  (last_char)
    );

endmodule
